// ===== design/svpd_pkg.sv =====
// ============================================================================
// svpd_pkg: shared types and constants of the stepper valve position drive
// Holds the command and status codes, the register map, the reset values and
// the coil pattern tables of the excitation modes.
// ============================================================================
package svpd_pkg;

    // Command codes carried on the input channel.
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_MOVE = 2'd1,
        OP_STOP = 2'd2
    } opcode_t;

    // Status codes reported with every result beat.
    typedef enum logic [1:0] {
        MS_OK      = 2'd0,
        MS_IGNORED = 2'd1,
        MS_STOPPED = 2'd2
    } move_status_t;

    // Excitation modes; any other code keeps the previous coil pattern.
    typedef enum logic [1:0] {
        EXC_ONE  = 2'd0,
        EXC_HALF = 2'd1,
        EXC_TWO  = 2'd2
    } exc_mode_t;

    // Register map of the configuration port.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXCITATION_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_OPEN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OVERRUN_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALL_OFFSET     = 3'd4;

    // Reset values of the registers.
    localparam logic [7:0]  RST_STEP_INTERVAL = 8'd16;
    localparam logic [1:0]  RST_EXC_MODE      = 2'd1;
    localparam logic        RST_NORMAL_OPEN   = 1'b1;
    localparam logic [15:0] RST_OVERRUN_LIMIT = 16'd200;
    localparam logic [15:0] RST_HALL_OFFSET   = 16'd50;

    // Configuration as seen by the step logic.
    typedef struct packed {
        logic [7:0]  step_interval;
        logic [1:0]  excitation_mode;
        logic        normal_open;
        logic [15:0] overrun_limit;
        logic [15:0] hall_offset;
    } cfg_t;

    // Complete drive state, updated once per input beat.
    typedef struct packed {
        logic [15:0] cur_position;
        logic [15:0] goal_position;
        logic [15:0] homing_overrun;
        logic [7:0]  pending_backout;
        logic [15:0] learned_overrun;
        logic [2:0]  coil_phase;
        logic [15:0] origin_position;
        logic        origin_seen;
        logic        run_flag;
        logic        stop_pending;
        logic        dir_flag;
        logic [7:0]  tick_count;
        logic [3:0]  coil_state;
    } drive_state_t;

    // Coil pattern for a phase in a given mode; unknown modes hold the old pattern.
    function automatic logic [3:0] coil_pattern(input logic [1:0] mode,
                                                input logic [2:0] phase,
                                                input logic [3:0] prev);
        logic [3:0] pat;
        pat = prev;
        unique case (mode)
            EXC_ONE: begin
                unique case (phase)
                    3'd0, 3'd1: pat = 4'd1;
                    3'd2, 3'd3: pat = 4'd2;
                    3'd4, 3'd5: pat = 4'd4;
                    default:    pat = 4'd8;
                endcase
            end
            EXC_HALF: begin
                unique case (phase)
                    3'd0:    pat = 4'd3;
                    3'd1:    pat = 4'd2;
                    3'd2:    pat = 4'd6;
                    3'd3:    pat = 4'd4;
                    3'd4:    pat = 4'd12;
                    3'd5:    pat = 4'd8;
                    3'd6:    pat = 4'd9;
                    default: pat = 4'd1;
                endcase
            end
            EXC_TWO: begin
                unique case (phase)
                    3'd0, 3'd1: pat = 4'd3;
                    3'd2, 3'd3: pat = 4'd6;
                    3'd4, 3'd5: pat = 4'd12;
                    default:    pat = 4'd9;
                endcase
            end
            default: pat = prev;
        endcase
        return pat;
    endfunction

endpackage

// ===== design/svpd_cfg.sv =====
// ============================================================================
// svpd_cfg: configuration registers
// Decodes writes on the plain write port into the five drive registers.
// ============================================================================
module svpd_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [svpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [svpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output svpd_pkg::cfg_t                 cfg
);
    import svpd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register decode; writes to unused indexes are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_STEP_INTERVAL:   cfg_next.step_interval   = cfg_wdata[7:0];
                REG_EXCITATION_MODE: cfg_next.excitation_mode = cfg_wdata[1:0];
                REG_NORMAL_OPEN:     cfg_next.normal_open     = cfg_wdata[0];
                REG_OVERRUN_LIMIT:   cfg_next.overrun_limit   = cfg_wdata;
                REG_HALL_OFFSET:     cfg_next.hall_offset     = cfg_wdata;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_interval   <= RST_STEP_INTERVAL;
            cfg_reg.excitation_mode <= RST_EXC_MODE;
            cfg_reg.normal_open     <= RST_NORMAL_OPEN;
            cfg_reg.overrun_limit   <= RST_OVERRUN_LIMIT;
            cfg_reg.hall_offset     <= RST_HALL_OFFSET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/svpd_step.sv =====
// ============================================================================
// svpd_step: drive step logic
// Works out the next drive state and the result of one command beat: the
// tick divider, the drive step, move acceptance and stop requests.
// ============================================================================
module svpd_step (
    input  svpd_pkg::cfg_t         cfg,
    input  svpd_pkg::drive_state_t st_cur,
    input  logic [1:0]             opcode,
    input  logic [15:0]            target,
    input  logic [7:0]             overshoot,
    input  logic                   origin_sensed,
    output svpd_pkg::drive_state_t st_new,
    output logic [1:0]             move_status
);
    import svpd_pkg::*;

    drive_state_t s;
    move_status_t status;
    logic [7:0]   tc;
    logic [15:0]  learn_v;
    logic [16:0]  open_goal;
    logic         go_on;

    always_comb begin
        s         = st_cur;
        status    = MS_OK;
        tc        = st_cur.tick_count;
        learn_v   = '0;
        open_goal = '0;
        go_on     = 1'b1;

        unique case (opcode)
            OP_TICK: begin
                // Divider counts down, a drive step runs when it reaches zero.
                if (tc != 8'd0) begin
                    tc = tc - 8'd1;
                end
                if (tc == 8'd0) begin
                    tc = cfg.step_interval;
                    if (!s.run_flag) begin
                        s.coil_state = 4'd0;
                    end else begin
                        if (s.stop_pending) begin
                            s.stop_pending  = 1'b0;
                            s.goal_position = s.cur_position;
                        end
                        if (s.goal_position > s.cur_position) begin
                            // Opening step, with overrun learning from the sensor.
                            s.cur_position = s.cur_position + 16'd1;
                            s.coil_phase   = cfg.normal_open ? s.coil_phase - 3'd1
                                                             : s.coil_phase + 3'd1;
                            if (origin_sensed) begin
                                s.origin_position = s.cur_position;
                                s.origin_seen     = 1'b1;
                            end else if (s.origin_seen) begin
                                learn_v = (s.origin_position > cfg.hall_offset)
                                        ? s.origin_position - cfg.hall_offset : 16'd0;
                                s.learned_overrun = (learn_v > cfg.overrun_limit)
                                                  ? cfg.overrun_limit : learn_v;
                            end
                            s.coil_state = coil_pattern(cfg.excitation_mode,
                                                        s.coil_phase, s.coil_state);
                        end else if (s.goal_position < s.cur_position) begin
                            if (origin_sensed &&
                                (s.homing_overrun >= s.learned_overrun)) begin
                                // Overrun limit reached past the origin sensor.
                                s.goal_position  = 16'd0;
                                s.cur_position   = 16'd0;
                                s.homing_overrun = 16'd0;
                                s.coil_state     = 4'd0;
                            end else begin
                                if (origin_sensed) begin
                                    s.homing_overrun = s.homing_overrun + 16'd1;
                                end
                                // Closing step.
                                if (s.cur_position != 16'd0) begin
                                    s.cur_position = s.cur_position - 16'd1;
                                    s.coil_phase   = cfg.normal_open
                                                   ? s.coil_phase + 3'd1
                                                   : s.coil_phase - 3'd1;
                                end else begin
                                    s.homing_overrun = 16'd0;
                                    s.run_flag       = 1'b0;
                                    s.goal_position  = 16'd0;
                                    s.coil_state     = 4'd0;
                                end
                                if (s.run_flag) begin
                                    s.coil_state = coil_pattern(cfg.excitation_mode,
                                                                s.coil_phase,
                                                                s.coil_state);
                                end
                            end
                        end else if ((s.goal_position != 16'd0) &&
                                     (s.pending_backout != 8'd0)) begin
                            // Goal reached on opening: back the overshoot out.
                            s.goal_position   = s.goal_position -
                                                {8'd0, s.pending_backout};
                            s.pending_backout = 8'd0;
                        end else begin
                            s.homing_overrun = 16'd0;
                            s.coil_state     = 4'd0;
                            s.run_flag       = 1'b0;
                        end
                    end
                end
                s.tick_count = tc;
            end
            OP_MOVE: begin
                // A running move may only continue in the same direction.
                if (s.run_flag) begin
                    if (s.dir_flag && (s.cur_position < target)) begin
                        go_on = 1'b1;
                    end else if (!s.dir_flag && (s.cur_position > target)) begin
                        if (target == 16'd0) begin
                            go_on  = 1'b0;
                            status = MS_IGNORED;
                        end
                    end else begin
                        go_on          = 1'b0;
                        s.stop_pending = 1'b1;
                        status         = MS_STOPPED;
                    end
                end
                if (go_on && (s.cur_position == target)) begin
                    go_on  = 1'b0;
                    status = MS_IGNORED;
                end
                if (go_on) begin
                    if (target == 16'd0) begin
                        s.homing_overrun = 16'd0;
                        s.goal_position  = 16'd0;
                    end else if (s.cur_position >= target) begin
                        s.dir_flag        = 1'b0;
                        s.homing_overrun  = 16'd0;
                        s.pending_backout = 8'd0;
                        s.goal_position   = target;
                    end else begin
                        // Opening goal saturates at full scale.
                        open_goal = {1'b0, target} + {9'd0, overshoot};
                        if (open_goal[16]) begin
                            open_goal = 17'h0FFFF;
                        end
                        s.dir_flag        = 1'b1;
                        s.goal_position   = open_goal[15:0];
                        s.pending_backout = 8'(open_goal[15:0] - target);
                    end
                    s.run_flag   = 1'b1;
                    s.tick_count = cfg.step_interval;
                end
            end
            OP_STOP: begin
                s.stop_pending = 1'b1;
            end
            default: begin
                s = st_cur;
            end
        endcase
    end

    assign st_new      = s;
    assign move_status = status;

endmodule

// ===== design/stepper_valve_position_drive.sv =====
// ============================================================================
// stepper_valve_position_drive: stepper valve position drive, top level
// Input register, drive state, step logic and result register.
// ============================================================================
// Usage
// Each input beat on the s_ channel is a timer tick, a move command or a
// stop request; every beat yields exactly one result beat on the m_ channel
// carrying the coil drive bits, the running flag, the position, the last
// direction and the move status. Configuration is written through the plain
// cfg_ write port while the drive is idle.
// A beat is held in the input register, then passes through the step logic
// into the result register. Throughput is one beat per cycle while the
// receiver does not stall, since the whole drive state is updated by
// combinational logic as the beat leaves the input register.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more beat; s_ready then falls until m_ready
// returns. Reset (aresetn low, synchronous) empties both registers, restores
// the register defaults and clears the drive state, with the coils off and
// the learned overrun set to the default overrun limit.
// ============================================================================
module stepper_valve_position_drive (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [svpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [svpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_opcode,
    input  logic [15:0]                     s_target,
    input  logic [7:0]                      s_overshoot,
    input  logic                            s_origin_sensed,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [3:0]                      m_coils,
    output logic                            m_running,
    output logic [15:0]                     m_position,
    output logic                            m_direction,
    output logic [1:0]                      m_move_status
);
    import svpd_pkg::*;

    cfg_t         cfg;
    drive_state_t st_reg;
    drive_state_t st_next;
    logic [1:0]   status_next;

    logic         in_valid_reg;
    logic [1:0]   in_opcode_reg;
    logic [15:0]  in_target_reg;
    logic [7:0]   in_overshoot_reg;
    logic         in_origin_reg;

    logic         res_valid_reg;
    logic [3:0]   res_coils_reg;
    logic         res_running_reg;
    logic [15:0]  res_position_reg;
    logic         res_direction_reg;
    logic [1:0]   res_status_reg;

    logic         advance;

    svpd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    svpd_step u_step (
        .cfg           (cfg),
        .st_cur        (st_reg),
        .opcode        (in_opcode_reg),
        .target        (in_target_reg),
        .overshoot     (in_overshoot_reg),
        .origin_sensed (in_origin_reg),
        .st_new        (st_next),
        .move_status   (status_next)
    );

    // A beat moves on when the result register is empty or being emptied.
    assign advance = in_valid_reg && (!res_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_opcode_reg    <= s_opcode;
            in_target_reg    <= s_target;
            in_overshoot_reg <= s_overshoot;
            in_origin_reg    <= s_origin_sensed;
        end
    end

    // Drive state, updated once per beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.cur_position    <= 16'd0;
            st_reg.goal_position   <= 16'd0;
            st_reg.homing_overrun  <= 16'd0;
            st_reg.pending_backout <= 8'd0;
            st_reg.learned_overrun <= RST_OVERRUN_LIMIT;
            st_reg.coil_phase      <= 3'd0;
            st_reg.origin_position <= 16'd0;
            st_reg.origin_seen     <= 1'b0;
            st_reg.run_flag        <= 1'b0;
            st_reg.stop_pending    <= 1'b0;
            st_reg.dir_flag        <= 1'b0;
            st_reg.tick_count      <= 8'd0;
            st_reg.coil_state      <= 4'd0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (advance) begin
            res_valid_reg <= 1'b1;
        end else if (m_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_coils_reg     <= st_next.coil_state;
            res_running_reg   <= st_next.run_flag;
            res_position_reg  <= st_next.cur_position;
            res_direction_reg <= st_next.dir_flag;
            res_status_reg    <= status_next;
        end
    end

    assign m_valid       = res_valid_reg;
    assign m_coils       = res_coils_reg;
    assign m_running     = res_running_reg;
    assign m_position    = res_position_reg;
    assign m_direction   = res_direction_reg;
    assign m_move_status = res_status_reg;

endmodule

// ===== dv/tb.sv =====
// ============================================================================
// tb: testbench of the stepper valve position drive
// Drives ticks, move commands and stop requests through the s_ channel with
// random gaps, predicts every result beat from its own copy of the drive
// state and compares each beat on the m_ channel field by field. Several
// register settings are used, the extremes among them, each written while
// the pipeline is empty.
// ============================================================================
module tb;
    import svpd_pkg::*;

    // Codes the package leaves unnamed: the spare opcode and excitation mode.
    localparam logic [1:0] OP_SPARE  = 2'd3;
    localparam logic [1:0] EXC_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 1750;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] target;
        logic [7:0]  overshoot;
        logic        origin;
    } drive_cmd_t;

    typedef struct packed {
        logic [3:0]   coils;
        logic         running;
        logic [15:0]  position;
        logic         direction;
        move_status_t status;
    } drive_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_opcode = '0;
    logic [15:0]           s_target = '0;
    logic [7:0]            s_overshoot = '0;
    logic                  s_origin_sensed = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [3:0]            m_coils;
    logic                  m_running;
    logic [15:0]           m_position;
    logic                  m_direction;
    logic [1:0]            m_move_status;

    stepper_valve_position_drive DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_target        (s_target),
        .s_overshoot     (s_overshoot),
        .s_origin_sensed (s_origin_sensed),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_coils         (m_coils),
        .m_running       (m_running),
        .m_position      (m_position),
        .m_direction     (m_direction),
        .m_move_status   (m_move_status)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Stimulus and scoreboard storage.
    drive_cmd_t    pending_cmds[$];
    drive_result_t awaited_results[$];
    drive_cmd_t    next_cmd;
    logic          in_taken = 1'b0;
    int            gap_left = 0;
    int            stall_left = 0;
    bit            quiet = 1'b0;
    int            sensor_zone = 4;
    int            items_sent = 0;
    int            mismatches = 0;
    int unsigned   cycle_count = 0;

    // Register copies used for prediction.
    logic [7:0]  cfg_interval;
    logic [1:0]  cfg_mode;
    logic        cfg_invert;
    logic [15:0] cfg_ovlimit;
    logic [15:0] cfg_offset;

    // Predicted drive state.
    logic [15:0] vpos, vgoal, over_count, over_cap, home_mark;
    logic [7:0]  backout, divider;
    logic [2:0]  ph;
    logic [3:0]  coil_bits;
    logic        home_mark_valid, moving, halt_req, opening;

    // Coil tables, phase 0 in the lowest nibble.
    localparam logic [31:0] TBL_ONE  = 32'h8844_2211;
    localparam logic [31:0] TBL_HALF = 32'h198C_4623;
    localparam logic [31:0] TBL_TWO  = 32'h99CC_6633;

    // ------------------------------------------------------------------------
    // Drive predictor
    // ------------------------------------------------------------------------

    // Coils follow the phase only while a move runs; a spare mode holds them.
    function automatic void refresh_coils();
        if (!moving)
            return;
        case (cfg_mode)
            EXC_ONE:  coil_bits = TBL_ONE[ph*4 +: 4];
            EXC_HALF: coil_bits = TBL_HALF[ph*4 +: 4];
            EXC_TWO:  coil_bits = TBL_TWO[ph*4 +: 4];
            default:  coil_bits = coil_bits;
        endcase
    endfunction

    // One pulse toward zero; at zero the move simply ends.
    function automatic void close_one();
        if (vpos != 16'd0) begin
            vpos = vpos - 16'd1;
            ph = cfg_invert ? ph + 3'd1 : ph - 3'd1;
        end else begin
            over_count = 16'd0;
            moving = 1'b0;
            vgoal = 16'd0;
            coil_bits = 4'd0;
        end
        refresh_coils();
    endfunction

    function automatic void drive_step(logic origin);
        logic [15:0] v;
        if (!moving) begin
            coil_bits = 4'd0;
            return;
        end
        if (halt_req) begin
            halt_req = 1'b0;
            vgoal = vpos;
        end
        if (vgoal > vpos) begin
            // Opening pulse; the homing overrun is relearned from the sensor.
            vpos = vpos + 16'd1;
            ph = cfg_invert ? ph - 3'd1 : ph + 3'd1;
            if (origin) begin
                home_mark = vpos;
                home_mark_valid = 1'b1;
            end else if (home_mark_valid) begin
                v = (home_mark > cfg_offset) ? home_mark - cfg_offset : 16'd0;
                over_cap = (v > cfg_ovlimit) ? cfg_ovlimit : v;
            end
            refresh_coils();
        end else if (vgoal < vpos) begin
            if (origin && over_count >= over_cap) begin
                // Overrun used up at the sensor: the position snaps to zero.
                vgoal = 16'd0;
                vpos = 16'd0;
                over_count = 16'd0;
                coil_bits = 4'd0;
            end else begin
                if (origin)
                    over_count = over_count + 16'd1;
                close_one();
            end
        end else if (vgoal != 16'd0 && backout != 8'd0) begin
            vgoal = vgoal - {8'd0, backout};
            backout = 8'd0;
        end else begin
            over_count = 16'd0;
            coil_bits = 4'd0;
            moving = 1'b0;
        end
    endfunction

    function automatic move_status_t start_move(logic [15:0] tgt, logic [7:0] os);
        logic [16:0] sum;
        if (moving) begin
            if (opening && vpos < tgt) begin
                // Keeps opening.
            end else if (!opening && vpos > tgt) begin
                if (tgt == 16'd0)
                    return MS_IGNORED;
            end else begin
                halt_req = 1'b1;
                return MS_STOPPED;
            end
        end
        if (vpos == tgt)
            return MS_IGNORED;
        if (tgt == 16'd0) begin
            over_count = 16'd0;
            vgoal = 16'd0;
        end else if (vpos >= tgt) begin
            opening = 1'b0;
            over_count = 16'd0;
            backout = 8'd0;
            vgoal = tgt;
        end else begin
            // Overshoot saturates; only the part actually added is backed out.
            sum = {1'b0, tgt} + {9'd0, os};
            if (sum > 17'h0FFFF)
                sum = 17'h0FFFF;
            opening = 1'b1;
            vgoal = sum[15:0];
            backout = sum[7:0] - tgt[7:0];
        end
        moving = 1'b1;
        divider = cfg_interval;
        return MS_OK;
    endfunction

    function automatic drive_result_t apply_command(drive_cmd_t c);
        drive_result_t r;
        r.status = MS_OK;
        case (c.opcode)
            OP_TICK: begin
                if (divider != 8'd0)
                    divider = divider - 8'd1;
                if (divider == 8'd0) begin
                    drive_step(c.origin);
                    divider = cfg_interval;
                end
            end
            OP_MOVE: r.status = start_move(c.target, c.overshoot);
            OP_STOP: halt_req = 1'b1;
            default: begin
                // The spare code only reports the state.
            end
        endcase
        r.coils = coil_bits;
        r.running = moving;
        r.position = vpos;
        r.direction = opening;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // The sensor is mostly on near the origin and rarely glitches elsewhere.
    function automatic logic origin_level();
        if (vpos < sensor_zone)
            return $urandom_range(0, 99) < 92;
        return $urandom_range(0, 99) < 4;
    endfunction

    task automatic send(logic [1:0] op, logic [15:0] tgt, logic [7:0] os, logic org);
        drive_cmd_t c;
        while (pending_cmds.size() >= 2)
            @(posedge aclk);
        c.opcode = op;
        c.target = tgt;
        c.overshoot = os;
        c.origin = org;
        pending_cmds.push_back(c);
        items_sent++;
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_STEP_INTERVAL:   cfg_interval = val[7:0];
            REG_EXCITATION_MODE: cfg_mode = val[1:0];
            REG_NORMAL_OPEN:     cfg_invert = val[0];
            REG_OVERRUN_LIMIT:   cfg_ovlimit = val;
            REG_HALL_OFFSET:     cfg_offset = val;
            default:             cfg_offset = cfg_offset;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(logic [7:0] iv, logic [1:0] md, logic inv,
                             logic [15:0] ol, logic [15:0] ho);
        set_reg(REG_STEP_INTERVAL, {8'd0, iv});
        set_reg(REG_EXCITATION_MODE, {14'd0, md});
        set_reg(REG_NORMAL_OPEN, {15'd0, inv});
        set_reg(REG_OVERRUN_LIMIT, ol);
        set_reg(REG_HALL_OFFSET, ho);
    endtask

    // Waits until every queued beat has gone and every result has come back.
    task automatic settle();
        while (pending_cmds.size() != 0 || s_valid || awaited_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // At most one command followed by a run of ticks, usually long enough to finish.
    task automatic random_episode(int tick_cap);
        int r, span, run, unit;
        logic [15:0] tgt;
        logic [7:0] os;
        r = $urandom_range(0, 99);
        if (r < 25)
            tgt = 16'd0;
        else if (r < 80)
            tgt = 16'($urandom_range(1, 60));
        else if (r < 90)
            tgt = ($urandom_range(0, 1) && vpos != 16'd0) ? vpos - 16'd1 : vpos;
        else if (r < 96)
            tgt = 16'($urandom);
        else
            tgt = 16'hFFFF - 16'($urandom_range(0, 200));
        r = $urandom_range(0, 99);
        if (r < 25)
            os = 8'd0;
        else if (r < 92)
            os = 8'($urandom_range(1, 12));
        else
            os = 8'($urandom);
        span = int'(tgt);
        span = span - int'(vpos);
        if (span < 0)
            span = -span;
        r = $urandom_range(0, 99);
        if (r < 78) begin
            send(OP_MOVE, tgt, os, origin_level());
        end else if (r < 86) begin
            send(OP_STOP, 16'($urandom), 8'($urandom), origin_level());
            span = 2;
        end else if (r < 89) begin
            send(OP_SPARE, 16'($urandom), 8'($urandom), origin_level());
        end
        unit = (cfg_interval == 8'd0) ? 1 : int'(cfg_interval);
        if ($urandom_range(0, 9) < 6)
            run = (span + 2 * int'(os) + 8) * unit;
        else
            run = $urandom_range(0, 12);
        if (run > tick_cap)
            run = tick_cap;
        repeat (run) send(OP_TICK, 16'($urandom), 8'($urandom), origin_level());
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver, receiver and monitor
    // ------------------------------------------------------------------------

    // Input side: a new beat goes out once the previous one has been taken.
    always @(negedge aclk) begin
        if (!s_valid || in_taken) begin
            if (gap_left > 0) begin
                s_valid <= 1'b0;
                gap_left--;
            end else if (pending_cmds.size() > 0) begin
                next_cmd = pending_cmds.pop_front();
                s_opcode <= next_cmd.opcode;
                s_target <= next_cmd.target;
                s_overshoot <= next_cmd.overshoot;
                s_origin_sensed <= next_cmd.origin;
                s_valid <= 1'b1;
                gap_left = quiet ? 0 : pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side: random stalls of the receiver.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            stall_left = pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Predict on every accepted input beat, check every accepted result beat.
    always @(posedge aclk) begin : monitor
        drive_cmd_t    beat;
        drive_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                beat.opcode = s_opcode;
                beat.target = s_target;
                beat.overshoot = s_overshoot;
                beat.origin = s_origin_sensed;
                awaited_results.push_back(apply_command(beat));
            end
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result beat with no expected result, position %0d", m_position);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("coils", want.coils, m_coils);
                    check_field("running", want.running, m_running);
                    check_field("position", want.position, m_position);
                    check_field("direction", want.direction, m_direction);
                    check_field("move_status", want.status, m_move_status);
                end
            end
        end
        in_taken <= aresetn && s_valid && s_ready;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int phase_no, budget, tick_cap, random_base;
        cfg_interval = RST_STEP_INTERVAL;
        cfg_mode = RST_EXC_MODE;
        cfg_invert = RST_NORMAL_OPEN;
        cfg_ovlimit = RST_OVERRUN_LIMIT;
        cfg_offset = RST_HALL_OFFSET;
        vpos = '0; vgoal = '0; over_count = '0; over_cap = RST_OVERRUN_LIMIT;
        home_mark = '0; backout = '0; divider = '0; ph = '0; coil_bits = '0;
        home_mark_valid = 1'b0; moving = 1'b0; halt_req = 1'b0; opening = 1'b0;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, one drive step per tick.
        set_reg(REG_STEP_INTERVAL, 16'd1);
        send(OP_TICK, 16'd0, 8'd0, 1'b0);           // idle step, coils off
        send(OP_STOP, 16'hFFFF, 8'hFF, 1'b1);       // stop request while idle
        send(OP_MOVE, 16'd5, 8'd0, 1'b0);
        repeat (2) send(OP_TICK, 16'd0, 8'd0, 1'b0); // pending stop cancels it
        send(OP_MOVE, 16'd0, 8'd0, 1'b0);           // already there: ignored
        send(OP_MOVE, 16'd3, 8'hFF, 1'b0);          // largest overshoot
        repeat (3) send(OP_TICK, 16'd0, 8'd0, 1'b0);
        send(OP_MOVE, 16'd10, 8'd2, 1'b1);          // same direction, carries on
        send(OP_MOVE, 16'd1, 8'd0, 1'b0);           // reversal turns into a stop
        repeat (3) send(OP_TICK, 16'd0, 8'd0, 1'b0); // stop with backout, then closing
        send(OP_SPARE, 16'h5A5A, 8'hA5, 1'b1);
        send(OP_MOVE, 16'hFFFF, 8'hFF, 1'b0);       // goal saturates at the top
        repeat (2) send(OP_TICK, 16'd0, 8'd0, 1'b1); // sensor seen while opening
        send(OP_MOVE, 16'd0, 8'd0, 1'b0);           // home while opening: stop
        repeat (2) send(OP_TICK, 16'd0, 8'd0, 1'b0);
        send(OP_MOVE, 16'd1, 8'd0, 1'b0);           // closing to a lower target
        send(OP_MOVE, 16'd0, 8'd0, 1'b0);           // home while closing: ignored
        repeat (3) send(OP_TICK, 16'd0, 8'd0, 1'b1);
        settle();

        // Random phases, each with its own register setting.
        random_base = items_sent;
        phase_no = 0;
        while (items_sent < random_base + RANDOM_ITEMS) begin
            budget = 220;
            tick_cap = 150;
            case (phase_no)
                0: configure(RST_STEP_INTERVAL, RST_EXC_MODE, RST_NORMAL_OPEN,
                             RST_OVERRUN_LIMIT, RST_HALL_OFFSET);
                1: configure(8'd0, EXC_ONE, 1'b0, 16'd3, 16'd0);
                2: configure(8'd1, EXC_TWO, 1'b1, 16'hFFFF, 16'd5);
                3: configure(8'd2, EXC_SPARE, 1'b0, 16'd0, 16'hFFFF);
                4: begin
                    configure(8'hFF, EXC_HALF, 1'b1, 16'd12, 16'd20);
                    budget = 270;
                    tick_cap = 260;
                end
                default: configure(8'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                   1'($urandom_range(0, 1)),
                                   16'($urandom_range(0, 1) ? $urandom_range(0, 12)
                                                            : $urandom),
                                   16'($urandom_range(0, 1) ? $urandom_range(0, 30)
                                                            : $urandom));
            endcase
            sensor_zone = $urandom_range(0, 40);
            quiet = ($urandom_range(0, 3) == 0);
            budget = items_sent + budget;
            while (items_sent < budget)
                random_episode(tick_cap);
            // The sender holds off here until every result is back.
            settle();
            phase_no++;
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
